// ===== src/sgmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgmc_pkg
// Shared types and constants for the sliding gate motor controller.
// ----------------------------------------------------------------------------
package sgmc_pkg;

    localparam int CAL_TIMEOUT_MS_DEF = 60000;
    localparam int OVERRUN_MS_DEF     = 3000;

    localparam logic [16:0] FULL_Q        = 17'd65536;
    localparam logic [16:0] NEAR_OPEN_Q   = 17'd64881;
    localparam logic [16:0] NEAR_CLOSED_Q = 17'd655;
    localparam logic [19:0] TT_MAX        = 20'hFFFFF;

    localparam logic [1:0] M_IDLE    = 2'd0;
    localparam logic [1:0] M_OPENING = 2'd1;
    localparam logic [1:0] M_CLOSING = 2'd2;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_OPEN   = 3'd1;
    localparam logic [2:0] OP_CLOSE  = 3'd2;
    localparam logic [2:0] OP_STOP   = 3'd3;
    localparam logic [2:0] OP_MOVE   = 3'd4;
    localparam logic [2:0] OP_CAL    = 3'd5;
    localparam logic [2:0] OP_CANCEL = 3'd6;

    localparam logic [2:0] CAL_OFF     = 3'd0;
    localparam logic [2:0] CAL_HOME    = 3'd1;
    localparam logic [2:0] CAL_MEASURE = 3'd2;
    localparam logic [2:0] CAL_VERIFY  = 3'd3;
    localparam logic [2:0] CAL_FINISH  = 3'd4;

    localparam logic [2:0] CFG_DRIVE_MODE = 3'd0;
    localparam logic [2:0] CFG_LIMIT_HI   = 3'd1;
    localparam logic [2:0] CFG_BARRIER_HI = 3'd2;
    localparam logic [2:0] CFG_RELAY_DLY  = 3'd3;
    localparam logic [2:0] CFG_TRAVEL     = 3'd4;
    localparam logic [2:0] CFG_BLINK_OPEN = 3'd5;
    localparam logic [2:0] CFG_BLINK_CLS  = 3'd6;
    localparam logic [2:0] CFG_BLINK_CAL  = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EXEC,
        ST_OUT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture request, start divider
        logic div_step; // one quotient bit
        logic exec;     // apply request to state, load output
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
    } dp_stat_t;

endpackage

// ===== src/sgmc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgmc_ctrl
// Sequencer: accept, divide, execute, present result.
// ----------------------------------------------------------------------------
module sgmc_ctrl
    import sgmc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    ctrl_state_t state_reg, state_next;
    logic        mvalid_reg, mvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        if (mvalid_reg && m_tready) mvalid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                // output register must be free before it is overwritten
                if (!mvalid_reg || m_tready) begin
                    cmd.exec    = 1'b1;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = mvalid_reg;

endmodule

// ===== src/sgmc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgmc_datapath
// Gate state, config registers, restoring divider and output register.
// ----------------------------------------------------------------------------
module sgmc_datapath
    import sgmc_pkg::*;
#(
    parameter int CAL_TIMEOUT_MS = CAL_TIMEOUT_MS_DEF,
    parameter int OVERRUN_MS     = OVERRUN_MS_DEF
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [2:0]  in_op,
    input  logic [16:0] in_target,
    input  logic        in_open_lim,
    input  logic        in_close_lim,
    input  logic        in_barrier,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [19:0] cfg_wdata,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output logic [47:0] out_data
);

    // configuration
    logic        mode_reg, lim_hi_reg, bar_hi_reg;
    logic [15:0] rdly_reg, bl_open_reg, bl_cls_reg, bl_cal_reg;

    // gate state
    logic [31:0] now_reg, rts_reg, mst_reg, cst_reg, blt_reg;
    logic [1:0]  mot_reg, pend_reg, lmbs_reg;
    logic [2:0]  cal_reg;
    logic [16:0] msp_reg, pos_reg, tgt_reg;
    logic [15:0] bint_reg;
    logic [19:0] wtt_reg;
    logic        rw_reg, tv_reg, lamp_reg, ar_reg;

    // captured request
    logic [2:0]  op_reg;
    logic [16:0] itgt_reg;
    logic        lo_reg, lc_reg, br_reg;

    // divider: elapsed << 16 over wtt, only needed when elapsed < wtt (< 2^20)
    logic [35:0] rem_reg;
    logic [16:0] quo_reg;
    logic [5:0]  dcnt_reg;
    logic [19:0] dnum_reg;

    logic [47:0] out_reg;

    // elapsed as it will be seen after the engage step of a tick
    logic [31:0] now1, el_pre;
    logic        eng_pre;
    assign now1    = now_reg + 32'd1;
    assign eng_pre = rw_reg && ((now1 - rts_reg) >= {16'd0, rdly_reg});
    assign el_pre  = eng_pre ? 32'd0 : (now1 - mst_reg);

    localparam logic [5:0] DIV_STEPS = 6'd36;

    logic [36:0] trial;
    assign trial = {rem_reg, dnum_reg[19]} - {17'd0, wtt_reg};
    assign stat.div_done = (dcnt_reg == DIV_STEPS - 6'd1);

    // divider uses the remainder shift form over 36 bits of numerator
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dcnt_reg <= '0;
            dnum_reg <= el_pre[19:0];
        end else if (cmd.div_step) begin
            dcnt_reg <= dcnt_reg + 6'd1;
            dnum_reg <= {dnum_reg[18:0], 1'b0};
            if (!trial[36]) begin
                rem_reg <= trial[35:0];
                quo_reg <= {quo_reg[15:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[34:0], dnum_reg[19]};
                quo_reg <= {quo_reg[15:0], 1'b0};
            end
        end
    end

    // -------- execution of one request, written as sequential updates --------
    logic        n_mode;
    logic [31:0] n_now, n_rts, n_mst, n_cst, n_blt;
    logic [1:0]  n_mot, n_pend, n_lmbs;
    logic [2:0]  n_cal;
    logic [16:0] n_msp, n_pos, n_tgt;
    logic [15:0] n_bint;
    logic [19:0] n_wtt;
    logic        n_rw, n_tv, n_lamp, n_ar, n_sc;

    logic        lim_o, lim_c, bar;
    logic [16:0] tg, ratio, diff;
    logic [31:0] el, t;
    logic [17:0] psum;
    logic        r1, r2;

    always_comb begin
        n_mode = mode_reg;
        n_now = now_reg; n_rts = rts_reg; n_mst = mst_reg; n_cst = cst_reg; n_blt = blt_reg;
        n_mot = mot_reg; n_pend = pend_reg; n_lmbs = lmbs_reg; n_cal = cal_reg;
        n_msp = msp_reg; n_pos = pos_reg; n_tgt = tgt_reg; n_bint = bint_reg;
        n_wtt = wtt_reg; n_rw = rw_reg; n_tv = tv_reg; n_lamp = lamp_reg; n_ar = ar_reg;
        n_sc = 1'b0;
        lim_o = (lo_reg == lim_hi_reg);
        lim_c = (lc_reg == lim_hi_reg);
        bar   = (br_reg == bar_hi_reg);
        tg    = (itgt_reg > FULL_Q) ? FULL_Q : itgt_reg;
        ratio = '0; diff = '0; el = '0; t = '0; psum = '0;

        unique case (op_reg)
            OP_TICK: begin
                n_now = now1;
                if (n_rw && ((n_now - n_rts) >= {16'd0, rdly_reg})) begin
                    n_rw = 1'b0; n_pend = M_IDLE; n_mst = n_now; n_msp = n_pos;
                end
                // position update
                if (n_mot != M_IDLE && !n_rw) begin
                    el = n_now - n_mst;
                    if (n_wtt == 20'd0 || el >= {12'd0, n_wtt}) ratio = FULL_Q;
                    else ratio = quo_reg;
                    if (n_mot == M_OPENING) begin
                        psum  = {1'b0, n_msp} + {1'b0, ratio};
                        n_pos = (psum > {1'b0, FULL_Q}) ? FULL_Q : psum[16:0];
                    end else begin
                        n_pos = (n_msp > ratio) ? n_msp - ratio : 17'd0;
                    end
                    if (n_tv && ((n_mot == M_OPENING && n_pos >= n_tgt) ||
                                 (n_mot == M_CLOSING && n_pos <= n_tgt))) begin
                        n_rw = 1'b0; n_pend = M_IDLE; n_bint = '0; n_mot = M_IDLE;
                        n_sc = 1'b1; n_pos = n_tgt; n_tv = 1'b0;
                    end
                    if (n_wtt != 20'd0 &&
                        {1'b0, el} > ({13'd0, n_wtt} + 33'(OVERRUN_MS))) begin
                        if (!(n_mot == M_IDLE && n_cal == CAL_OFF && !n_ar)) begin
                            n_rw = 1'b0; n_pend = M_IDLE; n_bint = '0; n_mot = M_IDLE;
                            n_sc = 1'b1;
                        end
                    end
                end
                // safety
                if (n_cal == CAL_OFF) begin
                    if (n_mot == M_OPENING && lim_o) begin
                        n_rw = 1'b0; n_pend = M_IDLE; n_bint = '0; n_mot = M_IDLE;
                        n_sc = 1'b1; n_pos = FULL_Q;
                    end
                    if (n_mot == M_CLOSING) begin
                        if (lim_c) begin
                            n_rw = 1'b0; n_pend = M_IDLE; n_bint = '0; n_mot = M_IDLE;
                            n_sc = 1'b1; n_pos = '0;
                        end
                        if (bar) begin
                            if (!(n_mot == M_IDLE && !n_ar)) begin
                                n_rw = 1'b0; n_pend = M_IDLE; n_bint = '0; n_mot = M_IDLE;
                                n_sc = 1'b1;
                            end
                            n_ar = 1'b1;
                            n_mot = M_OPENING; n_sc = 1'b1; n_bint = bl_open_reg;
                            n_rw = 1'b1; n_rts = n_now; n_pend = M_OPENING;
                        end
                    end
                end
                // calibration; stop is never skipped while a phase is active
                if (n_cal != CAL_OFF) begin
                    if ((n_now - n_cst) > 32'(CAL_TIMEOUT_MS)) begin
                        n_rw = 1'b0; n_pend = M_IDLE; n_bint = '0; n_mot = M_IDLE;
                        n_sc = 1'b1; n_cal = CAL_OFF;
                    end else begin
                        unique case (n_cal)
                            CAL_HOME: begin
                                if (lim_c) begin
                                    n_rw = 1'b0; n_pend = M_IDLE; n_bint = '0;
                                    n_cal = CAL_MEASURE;
                                    n_mot = M_OPENING; n_sc = 1'b1; n_bint = bl_open_reg;
                                    n_rw = 1'b1; n_rts = n_now; n_pend = M_OPENING;
                                end else if (n_mot != M_CLOSING) begin
                                    n_mot = M_CLOSING; n_sc = 1'b1; n_bint = bl_cls_reg;
                                    n_rw = 1'b1; n_rts = n_now; n_pend = M_CLOSING;
                                end
                            end
                            CAL_MEASURE: begin
                                if (lim_o) begin
                                    t = n_now - n_mst;
                                    n_wtt = (t > {12'd0, TT_MAX}) ? TT_MAX : t[19:0];
                                    n_rw = 1'b0; n_pend = M_IDLE; n_bint = '0;
                                    n_cal = CAL_VERIFY;
                                    n_mot = M_CLOSING; n_sc = 1'b1; n_bint = bl_cls_reg;
                                    n_rw = 1'b1; n_rts = n_now; n_pend = M_CLOSING;
                                end
                            end
                            CAL_VERIFY: begin
                                if (lim_c) begin
                                    n_rw = 1'b0; n_pend = M_IDLE; n_bint = '0;
                                    n_mot = M_IDLE; n_sc = 1'b1; n_cal = CAL_FINISH;
                                end
                            end
                            CAL_FINISH: begin
                                n_cal = CAL_OFF; n_bint = '0; n_pos = '0;
                            end
                            default: ;
                        endcase
                    end
                end
                // blink
                if (n_bint == 16'd0) n_lamp = 1'b0;
                else if ((n_now - n_blt) > {16'd0, n_bint}) begin
                    n_blt = n_now; n_lamp = !n_lamp;
                end
            end
            OP_OPEN: begin
                n_lmbs = M_IDLE;
                if (n_mot == M_IDLE && n_cal == CAL_OFF && n_pos < NEAR_OPEN_Q && !lim_o) begin
                    n_mot = M_OPENING; n_sc = 1'b1; n_bint = bl_open_reg;
                    n_rw = 1'b1; n_rts = n_now; n_pend = M_OPENING;
                end
            end
            OP_CLOSE: begin
                n_lmbs = M_IDLE;
                if (n_mot == M_IDLE && n_cal == CAL_OFF && n_pos > NEAR_CLOSED_Q &&
                    !lim_c && !bar) begin
                    n_mot = M_CLOSING; n_sc = 1'b1; n_bint = bl_cls_reg;
                    n_rw = 1'b1; n_rts = n_now; n_pend = M_CLOSING;
                end
            end
            OP_STOP: begin
                if (!(n_mot == M_IDLE && n_cal == CAL_OFF && !n_ar)) begin
                    if (n_mot != M_IDLE)
                        n_lmbs = (n_pos > NEAR_CLOSED_Q && n_pos < NEAR_OPEN_Q) ? n_mot : M_IDLE;
                    n_rw = 1'b0; n_pend = M_IDLE; n_bint = '0; n_mot = M_IDLE;
                    n_sc = 1'b1; n_tv = 1'b0; n_cal = CAL_OFF; n_ar = 1'b0;
                end
            end
            OP_MOVE: begin
                if (n_cal == CAL_OFF) begin
                    if (n_mot != M_IDLE) begin
                        n_rw = 1'b0; n_pend = M_IDLE; n_bint = '0; n_mot = M_IDLE;
                        n_sc = 1'b1;
                    end
                    diff = (n_pos > tg) ? n_pos - tg : tg - n_pos;
                    if (diff > NEAR_CLOSED_Q) begin
                        n_tgt = tg; n_tv = 1'b1;
                        n_mot = (tg > n_pos) ? M_OPENING : M_CLOSING;
                        n_sc = 1'b1;
                        n_bint = (tg > n_pos) ? bl_open_reg : bl_cls_reg;
                        n_rw = 1'b1; n_rts = n_now; n_pend = n_mot;
                    end
                end
            end
            OP_CAL: begin
                if (n_mot == M_IDLE && n_cal == CAL_OFF) begin
                    n_cal = CAL_HOME; n_bint = bl_cal_reg; n_cst = n_now;
                end
            end
            OP_CANCEL: begin
                if (n_cal != CAL_OFF) begin
                    n_rw = 1'b0; n_pend = M_IDLE; n_bint = '0; n_mot = M_IDLE;
                    n_sc = 1'b1; n_cal = CAL_OFF;
                end
            end
            default: ;
        endcase

        if (!n_mode) begin
            r1 = (n_mot == M_CLOSING);
            r2 = (n_mot != M_IDLE) && !n_rw;
        end else begin
            r1 = (n_mot == M_OPENING) && !n_rw;
            r2 = (n_mot == M_CLOSING) && !n_rw;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= in_op; itgt_reg <= in_target;
            lo_reg <= in_open_lim; lc_reg <= in_close_lim; br_reg <= in_barrier;
        end
        if (cmd.exec)
            out_reg <= {2'd0, n_sc, n_wtt, n_cal, n_pos, n_mot, n_lamp, r2, r1};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0; lim_hi_reg <= 1'b0; bar_hi_reg <= 1'b0;
            rdly_reg <= 16'd500; bl_open_reg <= 16'd500; bl_cls_reg <= 16'd250;
            bl_cal_reg <= 16'd100;
            now_reg <= '0; rts_reg <= '0; mst_reg <= '0; cst_reg <= '0; blt_reg <= '0;
            mot_reg <= M_IDLE; pend_reg <= M_IDLE; lmbs_reg <= M_IDLE; cal_reg <= CAL_OFF;
            msp_reg <= '0; pos_reg <= '0; tgt_reg <= '0; bint_reg <= '0; wtt_reg <= '0;
            rw_reg <= 1'b0; tv_reg <= 1'b0; lamp_reg <= 1'b0; ar_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                now_reg <= n_now; rts_reg <= n_rts; mst_reg <= n_mst; cst_reg <= n_cst;
                blt_reg <= n_blt; mot_reg <= n_mot; pend_reg <= n_pend; lmbs_reg <= n_lmbs;
                cal_reg <= n_cal; msp_reg <= n_msp; pos_reg <= n_pos; tgt_reg <= n_tgt;
                bint_reg <= n_bint; wtt_reg <= n_wtt; rw_reg <= n_rw; tv_reg <= n_tv;
                lamp_reg <= n_lamp; ar_reg <= n_ar;
            end
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_DRIVE_MODE: mode_reg    <= cfg_wdata[0];
                    CFG_LIMIT_HI:   lim_hi_reg  <= cfg_wdata[0];
                    CFG_BARRIER_HI: bar_hi_reg  <= cfg_wdata[0];
                    CFG_RELAY_DLY:  rdly_reg    <= cfg_wdata[15:0];
                    CFG_TRAVEL:     wtt_reg     <= cfg_wdata;
                    CFG_BLINK_OPEN: bl_open_reg <= cfg_wdata[15:0];
                    CFG_BLINK_CLS:  bl_cls_reg  <= cfg_wdata[15:0];
                    CFG_BLINK_CAL:  bl_cal_reg  <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    assign out_data = out_reg;

endmodule

// ===== src/sliding_gate_motor_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_gate_motor_controller
// Top level: request stream in, one status result per request out.
// ----------------------------------------------------------------------------
// Each request (a 1 ms tick or a command) passes through the capture edge,
// the 36 steps of the bit-serial divider that forms the traveled fraction
// elapsed*65536 over the working travel time, then the edge that updates the
// gate state and loads the output register, after which its result is valid.
// A new request is accepted in the cycle after that update and not before; a
// result still waiting when the next request reaches its update step holds
// that request back there. Configuration writes (index 0..7 on cfg_addr) are
// to be made only while idle; the user is bound to this, the block itself
// does not enforce it. Writing the travel-time preset loads it straight into
// the working travel time.
// ----------------------------------------------------------------------------
module sliding_gate_motor_controller
    import sgmc_pkg::*;
#(
    parameter int CAL_TIMEOUT_MS = CAL_TIMEOUT_MS_DEF,
    parameter int OVERRUN_MS     = OVERRUN_MS_DEF
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] operation, [19:3] target_position, [20] open_limit_raw,
    // [21] close_limit_raw, [22] barrier_raw
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] relay_one, [1] relay_two, [2] indicator_lamp, [4:3] motion,
    // [21:5] position, [24:22] calibration_phase, [44:25] working travel ms,
    // [45] status_changed
    output logic [47:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [19:0] cfg_wdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sgmc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    sgmc_datapath #(
        .CAL_TIMEOUT_MS (CAL_TIMEOUT_MS),
        .OVERRUN_MS     (OVERRUN_MS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_op        (s_tdata[2:0]),
        .in_target    (s_tdata[19:3]),
        .in_open_lim  (s_tdata[20]),
        .in_close_lim (s_tdata[21]),
        .in_barrier   (s_tdata[22]),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .stat         (stat),
        .out_data     (m_tdata)
    );

endmodule
